// ===== src/ifd_pkg.sv =====
// shared types, constants and register codes for the ir async frame decoder
// used by every module of the block; no dependencies
`default_nettype none

package ifd_pkg;

	localparam int unsigned MAX_BYTES       = 16;
	localparam int unsigned SLOTS_PER_FRAME = 10;
	localparam int unsigned MAX_CELLS       = 9;
	localparam int unsigned MIN_TIMINGS     = 6;
	localparam int unsigned BYTE_BITS       = 8;

	localparam int unsigned DUR_W  = 16;
	localparam int unsigned TICK_W = 13;
	localparam int unsigned TOL_W  = 16;
	localparam int unsigned GAP_W  = 16;
	localparam int unsigned ACC_W  = 17;
	localparam int unsigned CELL_W = 4;
	localparam int unsigned SLOT_W = 4;
	localparam int unsigned IDX_W  = 4;
	localparam int unsigned CNT_W  = 5;
	localparam int unsigned TC_W   = 3;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned BITS_W = 8;

	localparam int unsigned CFG_AW = 2;
	localparam int unsigned CFG_DW = 16;
	localparam int unsigned IN_DW  = 16;
	localparam int unsigned OUT_DW = 24;

	localparam logic [CFG_AW-1:0] REG_TICK = 2'd0;
	localparam logic [CFG_AW-1:0] REG_TOL  = 2'd1;
	localparam logic [CFG_AW-1:0] REG_GAP  = 2'd2;

	localparam logic [TICK_W-1:0] TICK_RST = 13'd417;
	localparam logic [TOL_W-1:0]  TOL_RST  = 16'd150;
	localparam logic [GAP_W-1:0]  GAP_RST  = 16'd5000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_CLASS,
		ST_CELLS,
		ST_DONE
	} ifd_state_t;

	typedef enum logic [1:0] {
		CLS_IDLE,
		CLS_STEP,
		CLS_CHECK
	} ifd_cls_state_t;

	// command from the sequencer to the frame state
	typedef struct packed {
		logic clear;
		logic sat_check;
		logic advance;
		logic level;
		logic stop;
		logic fail;
	} ifd_cmd_t;

	// frame state back to the sequencer
	typedef struct packed {
		logic              stopped;
		logic              failed;
		logic              emit;
		logic [BYTE_W-1:0] emit_byte;
		logic [CNT_W-1:0]  bytes_done;
	} ifd_stat_t;

	// classifier result, done is a one-cycle strobe
	typedef struct packed {
		logic              done;
		logic              bad;
		logic [CELL_W-1:0] cells;
	} ifd_cls_t;

endpackage

`default_nettype wire

// ===== src/ifd_cell_class.sv =====
// rounds a duration to a whole number of bit cells by stepping an accumulator by the tick
// and checks it against the tolerance; depends on ifd_pkg
`default_nettype none

module ifd_cell_class (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire [ifd_pkg::DUR_W-1:0]   dur,
	input  wire [ifd_pkg::TICK_W-1:0]  tick,
	input  wire [ifd_pkg::TOL_W-1:0]   tol,
	output ifd_pkg::ifd_cls_t          cls
);

	ifd_pkg::ifd_cls_state_t state_q, state_d;

	logic [ifd_pkg::ACC_W-1:0]  acc_q, acc_d;
	logic [ifd_pkg::ACC_W-1:0]  lim_q, lim_d;
	logic [ifd_pkg::CELL_W-1:0] n_q, n_d;
	logic [ifd_pkg::TICK_W-1:0] t;
	logic [ifd_pkg::ACC_W-1:0]  t_ext;
	logic [ifd_pkg::ACC_W-1:0]  nxt;
	logic [ifd_pkg::ACC_W-1:0]  dur_ext;
	logic [ifd_pkg::ACC_W-1:0]  diff;

	// zero tick counts as one
	assign t       = (tick == '0) ? ifd_pkg::TICK_W'(1) : tick;
	assign t_ext   = ifd_pkg::ACC_W'(t);
	assign dur_ext = ifd_pkg::ACC_W'(dur);
	assign nxt     = acc_q + t_ext;
	assign diff    = (dur_ext > acc_q) ? (dur_ext - acc_q) : (acc_q - dur_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ifd_pkg::CLS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
		lim_q <= lim_d;
		n_q   <= n_d;
	end

	always_comb begin
		state_d   = state_q;
		acc_d     = acc_q;
		lim_d     = lim_q;
		n_d       = n_q;
		cls.done  = 1'b0;
		cls.bad   = 1'b0;
		cls.cells = n_q;
		unique case (state_q)
			ifd_pkg::CLS_IDLE: begin
				if (start) begin
					// at least one cell, rounding limit is dur + tick/2
					acc_d   = t_ext;
					n_d     = ifd_pkg::CELL_W'(1);
					lim_d   = dur_ext + ifd_pkg::ACC_W'(t >> 1);
					state_d = ifd_pkg::CLS_STEP;
				end
			end
			ifd_pkg::CLS_STEP: begin
				if ((n_q < ifd_pkg::CELL_W'(ifd_pkg::MAX_CELLS)) && (nxt <= lim_q)) begin
					acc_d = nxt;
					n_d   = n_q + ifd_pkg::CELL_W'(1);
				end else begin
					state_d = ifd_pkg::CLS_CHECK;
				end
			end
			ifd_pkg::CLS_CHECK: begin
				cls.done = 1'b1;
				cls.bad  = (dur == '0) || (diff > ifd_pkg::ACC_W'(tol));
				state_d  = ifd_pkg::CLS_IDLE;
			end
			default: begin
				state_d = ifd_pkg::CLS_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/ifd_frame.sv =====
// frame slot walker: start slot, eight data bits lsb first, stop slot,
// one cell per command, plus stop/fail flags and byte count; depends on ifd_pkg
`default_nettype none

module ifd_frame (
	input  wire                clk,
	input  wire                arst_n,
	input  ifd_pkg::ifd_cmd_t  cmd,
	output ifd_pkg::ifd_stat_t stat
);

	logic [ifd_pkg::SLOT_W-1:0] slot_q;
	logic [ifd_pkg::BYTE_W-1:0] shift_q;
	logic [ifd_pkg::IDX_W-1:0]  idx_q;
	logic [ifd_pkg::CNT_W-1:0]  bc_q;
	logic                       stopped_q;
	logic                       failed_q;
	logic                       at_start;
	logic                       at_stop;
	logic                       room;

	assign at_start = (slot_q == '0);
	assign at_stop  = (slot_q == ifd_pkg::SLOT_W'(ifd_pkg::SLOTS_PER_FRAME - 1));
	assign room     = (bc_q < ifd_pkg::CNT_W'(ifd_pkg::MAX_BYTES));

	assign stat.stopped    = stopped_q;
	assign stat.failed     = failed_q;
	assign stat.emit       = cmd.advance && at_stop && cmd.level && room;
	assign stat.emit_byte  = shift_q;
	assign stat.bytes_done = bc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			shift_q   <= '0;
			idx_q     <= '0;
			bc_q      <= '0;
			stopped_q <= 1'b0;
			failed_q  <= 1'b0;
		end else if (cmd.clear) begin
			slot_q    <= '0;
			shift_q   <= '0;
			idx_q     <= '0;
			bc_q      <= '0;
			stopped_q <= 1'b0;
			failed_q  <= 1'b0;
		end else begin
			// store full stops decoding at the start of the next item
			if (cmd.sat_check && !room) begin
				stopped_q <= 1'b1;
			end
			if (cmd.stop) begin
				stopped_q <= 1'b1;
			end
			if (cmd.fail) begin
				failed_q <= 1'b1;
			end
			if (cmd.advance) begin
				if (at_start) begin
					// a high start slot ends the frame sequence
					if (cmd.level) begin
						stopped_q <= 1'b1;
					end else begin
						shift_q <= '0;
						idx_q   <= '0;
						slot_q  <= ifd_pkg::SLOT_W'(1);
					end
				end else if (at_stop) begin
					if (!cmd.level) begin
						failed_q <= 1'b1;
					end else begin
						if (room) begin
							bc_q <= bc_q + ifd_pkg::CNT_W'(1);
						end
						slot_q <= '0;
					end
				end else begin
					if (cmd.level && (idx_q < ifd_pkg::IDX_W'(ifd_pkg::BYTE_BITS))) begin
						shift_q[idx_q[2:0]] <= 1'b1;
					end
					idx_q  <= idx_q + ifd_pkg::IDX_W'(1);
					slot_q <= slot_q + ifd_pkg::SLOT_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/ir_async_frame_decoder.sv =====
// an accepted transaction goes through start, class, cells and done; the classifier adds
// one tick multiple per cycle (up to nine), then the frame walker takes one cell
// per cycle (up to nine). one item in flight: no new transaction is taken until the last
// has left done, and a result waits in the output register while the next item is accepted.
// reset (arst_n low) clears decode state and sets tick/tolerance/gap to 417/150/5000.
// top level: sequencer, config registers, output register; depends on ifd_pkg
`default_nettype none

module ir_async_frame_decoder (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [ifd_pkg::CFG_AW-1:0]    cfg_addr,
	input  wire [ifd_pkg::CFG_DW-1:0]    cfg_wdata,
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire [ifd_pkg::IN_DW-1:0]     s_axis_tdata,  // [15:0] duration_us
	input  wire                          s_axis_tuser,  // [0] first_timing
	input  wire                          s_axis_tlast,  // last_timing
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	// [7:0] byte_value, [8] success, [13:9] byte_total, [21:14] bit_total, [23:22] zero
	output logic [ifd_pkg::OUT_DW-1:0]   m_axis_tdata,
	output logic                         m_axis_tuser,  // [0] byte_valid
	output logic                         m_axis_tlast   // verdict_valid
);

	ifd_pkg::ifd_state_t state_q, state_d;
	ifd_pkg::ifd_cmd_t   cmd;
	ifd_pkg::ifd_stat_t  stat;
	ifd_pkg::ifd_cls_t   cls;

	logic [ifd_pkg::TICK_W-1:0] tick_q;
	logic [ifd_pkg::TOL_W-1:0]  tol_q;
	logic [ifd_pkg::GAP_W-1:0]  gap_q;

	logic [ifd_pkg::DUR_W-1:0]  dur_q;
	logic                       last_q;
	logic                       level_q;
	logic                       level_parity_q;
	logic [ifd_pkg::TC_W-1:0]   tc_q;
	logic [ifd_pkg::TC_W-1:0]   tc_base;
	logic [ifd_pkg::CELL_W-1:0] cells_left_q;
	logic                       bvalid_q;
	logic [ifd_pkg::BYTE_W-1:0] bvalue_q;

	logic                       m_valid_q;
	logic [ifd_pkg::OUT_DW-1:0] m_data_q;
	logic                       m_user_q;
	logic                       m_last_q;

	logic                       accept;
	logic                       cls_start;
	logic                       load_out;
	logic                       ok;

	assign s_axis_tready = (state_q == ifd_pkg::ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign tc_base       = s_axis_tuser ? '0 : tc_q;
	assign ok            = last_q && !stat.failed
	                       && (tc_q >= ifd_pkg::TC_W'(ifd_pkg::MIN_TIMINGS))
	                       && (stat.bytes_done != '0);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

	ifd_cell_class u_cell_class (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cls_start),
		.dur    (dur_q),
		.tick   (tick_q),
		.tol    (tol_q),
		.cls    (cls)
	);

	ifd_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= ifd_pkg::TICK_RST;
			tol_q  <= ifd_pkg::TOL_RST;
			gap_q  <= ifd_pkg::GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ifd_pkg::REG_TICK: tick_q <= cfg_wdata[ifd_pkg::TICK_W-1:0];
				ifd_pkg::REG_TOL:  tol_q  <= cfg_wdata[ifd_pkg::TOL_W-1:0];
				ifd_pkg::REG_GAP:  gap_q  <= cfg_wdata[ifd_pkg::GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ifd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.level     = level_q;
		cls_start     = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			ifd_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.clear     = s_axis_tuser;
					cmd.sat_check = 1'b1;
					state_d       = ifd_pkg::ST_START;
				end
			end
			ifd_pkg::ST_START: begin
				if (stat.stopped || stat.failed) begin
					state_d = ifd_pkg::ST_DONE;
				end else begin
					cls_start = 1'b1;
					state_d   = ifd_pkg::ST_CLASS;
				end
			end
			ifd_pkg::ST_CLASS: begin
				if (cls.done) begin
					if (cls.bad) begin
						// a long high gap ends cleanly, anything else bad fails
						if (level_q && (dur_q >= gap_q)) begin
							cmd.stop = 1'b1;
						end else begin
							cmd.fail = 1'b1;
						end
						state_d = ifd_pkg::ST_DONE;
					end else begin
						state_d = ifd_pkg::ST_CELLS;
					end
				end
			end
			ifd_pkg::ST_CELLS: begin
				if (stat.stopped || stat.failed || (cells_left_q == '0)) begin
					state_d = ifd_pkg::ST_DONE;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			ifd_pkg::ST_DONE: begin
				if (!m_valid_q || m_axis_tready) begin
					load_out  = 1'b1;
					cmd.clear = last_q;
					state_d   = ifd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ifd_pkg::ST_IDLE;
			end
		endcase
	end

	// per-item control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_parity_q <= 1'b0;
			tc_q           <= '0;
			bvalid_q       <= 1'b0;
			cells_left_q   <= '0;
		end else begin
			if (accept) begin
				bvalid_q <= 1'b0;
				tc_q     <= (tc_base < ifd_pkg::TC_W'(ifd_pkg::MIN_TIMINGS))
				            ? tc_base + ifd_pkg::TC_W'(1) : tc_base;
			end
			if (stat.emit) begin
				bvalid_q <= 1'b1;
			end
			if ((state_q == ifd_pkg::ST_CLASS) && cls.done) begin
				cells_left_q <= cls.cells;
			end else if (cmd.advance) begin
				cells_left_q <= cells_left_q - ifd_pkg::CELL_W'(1);
			end
			if (load_out) begin
				// a verdict returns the decode to its reset state
				level_parity_q <= last_q ? 1'b0 : ~level_q;
				if (last_q) begin
					tc_q <= '0;
				end
			end
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			dur_q    <= s_axis_tdata[ifd_pkg::DUR_W-1:0];
			last_q   <= s_axis_tlast;
			level_q  <= s_axis_tuser ? 1'b0 : level_parity_q;
			bvalue_q <= '0;
		end else if (stat.emit) begin
			bvalue_q <= stat.emit_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= {2'b00,
			             stat.bytes_done, 3'b000,
			             stat.bytes_done,
			             ok,
			             bvalue_q};
			m_user_q <= bvalid_q;
			m_last_q <= last_q;
		end
	end

endmodule

`default_nettype wire

// ===== src/ifd_checker.sv =====
// port-level checks on the ir async frame decoder, bound to the top level
// depends on ifd_pkg and ir_async_frame_decoder
`default_nettype none

module ifd_checker (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_axis_tvalid,
	input  wire                        s_axis_tready,
	input  wire                        m_axis_tvalid,
	input  wire                        m_axis_tready,
	input  wire [ifd_pkg::OUT_DW-1:0]  m_axis_tdata,
	input  wire                        m_axis_tuser,
	input  wire                        m_axis_tlast
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// one item at a time: no accept in the cycle after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while busy");

	// bit total is always eight per byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[21:14] == {m_axis_tdata[13:9], 3'b000})
		else $error("bit total does not match byte total");

	// success only comes with a verdict
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !m_axis_tdata[8])
		else $error("success without verdict");

	// byte value is zero when no byte completed
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
		else $error("byte value without byte");

endmodule

bind ir_async_frame_decoder ifd_checker u_ifd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== bench/ifd_frame_checker.sv =====
`timescale 1ns / 1ps
// decode checker for ir_async_frame_decoder: follows register writes and both
// stream channels, predicts every result and compares it; depends on ifd_pkg

module ifd_frame_checker (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire [ifd_pkg::CFG_AW-1:0]  cfg_addr,
	input  wire [ifd_pkg::CFG_DW-1:0]  cfg_wdata,
	input  wire                        s_tvalid,
	input  wire                        s_tready,
	input  wire [ifd_pkg::IN_DW-1:0]   s_tdata,   // [15:0] duration_us
	input  wire                        s_tuser,   // [0] first_timing
	input  wire                        s_tlast,   // last_timing
	input  wire                        m_tvalid,
	input  wire                        m_tready,
	// [7:0] byte_value, [8] success, [13:9] byte_total, [21:14] bit_total, [23:22] zero
	input  wire [ifd_pkg::OUT_DW-1:0]  m_tdata,
	input  wire                        m_tuser,   // [0] byte_valid
	input  wire                        m_tlast,   // verdict_valid
	output int                         mismatches,
	output int                         pending
);
	import ifd_pkg::*;

	typedef struct packed {
		logic              byte_valid;
		logic [BYTE_W-1:0] byte_value;
		logic              verdict;
		logic              success;
		logic [CNT_W-1:0]  byte_total;
		logic [BITS_W-1:0] bit_total;
	} decode_result_t;

	decode_result_t decoded_q[$];

	logic [TICK_W-1:0] cell_tick;
	logic [TOL_W-1:0]  cell_tol;
	logic [GAP_W-1:0]  gap_min;

	logic              parity;
	logic [TC_W-1:0]   timings_seen;
	logic [SLOT_W-1:0] slot;
	logic [BYTE_W-1:0] shreg;
	logic [IDX_W-1:0]  bit_pos;
	logic [CNT_W-1:0]  byte_cnt;
	logic              halted;
	logic              broken;

	initial mismatches = 0;
	initial pending = 0;

	task automatic clear_decode_state;
		parity       = 1'b0;
		timings_seen = '0;
		slot         = '0;
		shreg        = '0;
		bit_pos      = '0;
		byte_cnt     = '0;
		halted       = 1'b0;
		broken       = 1'b0;
	endtask

	// whole cells in a duration, zero when it is off the tick grid
	function automatic int unsigned cells_in(input logic [DUR_W-1:0] dur);
		int unsigned t, n, target, diff;
		t = (cell_tick == 0) ? 1 : cell_tick;
		if (dur == 0)
			return 0;
		n = (dur + t / 2) / t;
		if (n == 0)
			n = 1;
		if (n > MAX_CELLS)
			n = MAX_CELLS;
		target = n * t;
		diff = (dur > target) ? dur - target : target - dur;
		if (diff > cell_tol)
			return 0;
		return n;
	endfunction

	task automatic decode_timing(input logic [DUR_W-1:0] dur, input logic first,
			input logic last);
		decode_result_t r;
		int unsigned cells;
		logic lv;
		r = '0;
		if (first)
			clear_decode_state();
		lv = parity;
		if (timings_seen < MIN_TIMINGS)
			timings_seen++;
		if (byte_cnt >= MAX_BYTES)
			halted = 1'b1;
		if (!halted && !broken) begin
			cells = cells_in(dur);
			if (cells == 0) begin
				// a long space ends the frames cleanly, anything else is an error
				if (lv && dur >= gap_min)
					halted = 1'b1;
				else
					broken = 1'b1;
			end
			for (int c = 0; c < cells; c++) begin
				if (halted || broken)
					break;
				if (slot == 0) begin
					if (lv) begin
						halted = 1'b1;
						break;
					end
					shreg = '0;
					bit_pos = '0;
				end else if (slot == SLOTS_PER_FRAME - 1) begin
					if (!lv) begin
						broken = 1'b1;
						break;
					end
					if (byte_cnt < MAX_BYTES) begin
						byte_cnt++;
						r.byte_valid = 1'b1;
						r.byte_value = shreg;
					end
				end else begin
					if (lv && bit_pos < BYTE_BITS)
						shreg[bit_pos[2:0]] = 1'b1;
					bit_pos++;
				end
				slot = (slot == SLOTS_PER_FRAME - 1) ? '0 : slot + 1'b1;
			end
		end
		parity = ~lv;
		r.verdict = last;
		if (last)
			r.success = !broken && timings_seen >= MIN_TIMINGS && byte_cnt >= 1;
		r.byte_total = byte_cnt;
		r.bit_total = BITS_W'(byte_cnt) << 3;
		decoded_q.push_back(r);
		if (last)
			clear_decode_state();
	endtask

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			if (mismatches < 10)
				$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, name,
					want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		decode_result_t want;
		if (!arst_n) begin
			cell_tick = TICK_RST;
			cell_tol  = TOL_RST;
			gap_min   = GAP_RST;
			clear_decode_state();
			decoded_q.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (decoded_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t result with no duration waiting: tdata %h", $realtime,
							m_tdata);
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					compare_field("byte_valid", want.byte_valid, m_tuser);
					compare_field("byte_value", want.byte_value, m_tdata[7:0]);
					compare_field("verdict_valid", want.verdict, m_tlast);
					compare_field("success", want.success, m_tdata[8]);
					compare_field("byte_total", want.byte_total, m_tdata[13:9]);
					compare_field("bit_total", want.bit_total, m_tdata[21:14]);
					compare_field("tdata padding", 0, m_tdata[23:22]);
				end
			end
			if (cfg_we) begin
				case (cfg_addr)
					REG_TICK: cell_tick = cfg_wdata[TICK_W-1:0];
					REG_TOL:  cell_tol  = cfg_wdata[TOL_W-1:0];
					REG_GAP:  gap_min   = cfg_wdata[GAP_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				decode_timing(s_tdata, s_tuser, s_tlast);
			pending <= decoded_q.size();
		end
	end

endmodule

// ===== bench/tb_ir_async_frame_decoder.sv =====
`timescale 1ns / 1ps
// testbench top for ir_async_frame_decoder: clock, reset, register settings,
// capture stimulus and verdict; depends on ifd_pkg and ifd_frame_checker

module tb_ir_async_frame_decoder;
	import ifd_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 1800;
	localparam int PHASES       = 8;

	logic clk;
	logic arst_n = 1'b0;

	logic              cfg_we    = 1'b0;
	logic [CFG_AW-1:0] cfg_addr  = '0;
	logic [CFG_DW-1:0] cfg_wdata = '0;

	logic              s_tvalid = 1'b0;
	wire               s_tready;
	logic [IN_DW-1:0]  s_tdata  = '0;  // [15:0] duration_us
	logic              s_tuser  = 1'b0;  // [0] first_timing
	logic              s_tlast  = 1'b0;  // last_timing

	wire               m_tvalid;
	logic              m_tready = 1'b0;
	// [7:0] byte_value, [8] success, [13:9] byte_total, [21:14] bit_total, [23:22] zero
	wire [OUT_DW-1:0]  m_tdata;
	wire               m_tuser;  // [0] byte_valid
	wire               m_tlast;  // verdict_valid

	int mismatches;
	int outstanding;

	logic [TICK_W-1:0] cur_tick = TICK_RST;
	logic [TOL_W-1:0]  cur_tol  = TOL_RST;
	logic [GAP_W-1:0]  cur_gap  = GAP_RST;

	bit src_idle = 1'b1;
	bit snk_idle = 1'b1;
	bit hold_req = 1'b0;
	int sent = 0;

	logic [7:0] payload [0:19];

	ir_async_frame_decoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.s_axis_tlast  (s_tlast),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.m_axis_tlast  (m_tlast)
	);

	ifd_frame_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pending    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("[ir_async_frame_decoder] ERROR");
		$finish;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (snk_idle && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic push_timing(input logic [DUR_W-1:0] dur, input bit first, input bit last);
		if (src_idle && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= dur;
		s_tuser  <= first;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	// drop valid and let the block run empty before touching registers
	task automatic wait_idle;
		s_tvalid <= 1'b0;
		// the count of waiting results is a registered copy of the queue size
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input logic [CFG_DW-1:0] tick_word, input logic [TOL_W-1:0] tol,
			input logic [GAP_W-1:0] gap);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_TICK;
		cfg_wdata <= tick_word;
		@(posedge clk);
		cfg_addr  <= REG_TOL;
		cfg_wdata <= tol;
		@(posedge clk);
		cfg_addr  <= REG_GAP;
		cfg_wdata <= gap;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_tick = tick_word[TICK_W-1:0];
		cur_tol  = tol;
		cur_gap  = gap;
	endtask

	// duration of a run of cells with jitter kept inside the tolerance
	function automatic logic [DUR_W-1:0] run_duration(input int unsigned cells);
		int unsigned t, jmax;
		int d;
		t = (cur_tick == 0) ? 1 : cur_tick;
		jmax = (t - 1) / 2;
		if (cur_tol < jmax)
			jmax = cur_tol;
		d = int'(cells * t) + int'($urandom_range(0, 2 * jmax)) - int'(jmax);
		if (d < 0)
			d = 0;
		if (d > 65535)
			d = 65535;
		return DUR_W'(d);
	endfunction

	// tail: 0 ends on the last stop run, 1 stretches it into a high start slot,
	// 2 adds a partial start run and a long space
	task automatic send_capture(input int nbytes, input int tail, input bit noisy);
		bit lv[$];
		int unsigned runs[$];
		logic [DUR_W-1:0] durs[$];
		bit cur;
		int unsigned n;
		int unsigned g;
		bit first;
		lv.delete();
		runs.delete();
		durs.delete();
		for (int b = 0; b < nbytes; b++) begin
			lv.push_back(1'b0);
			for (int i = 0; i < 8; i++)
				lv.push_back(payload[b][i]);
			lv.push_back(1'b1);
		end
		cur = lv[0];
		n = 0;
		foreach (lv[i]) begin
			if (lv[i] == cur) begin
				n++;
			end else begin
				runs.push_back(n);
				cur = lv[i];
				n = 1;
			end
		end
		runs.push_back(n);
		if (tail == 1) begin
			n = runs[runs.size() - 1] + $urandom_range(1, 3);
			runs[runs.size() - 1] = (n > MAX_CELLS) ? MAX_CELLS : n;
		end else if (tail == 2) begin
			runs.push_back($urandom_range(1, MAX_CELLS));
		end
		foreach (runs[i])
			durs.push_back(run_duration(runs[i]));
		if (tail == 2) begin
			g = cur_gap + $urandom_range(0, 3000);
			durs.push_back((g > 65535) ? 16'hFFFF : DUR_W'(g));
		end
		if (noisy && $urandom_range(0, 7) == 0)
			durs[$urandom_range(0, durs.size() - 1)] = DUR_W'($urandom);
		foreach (durs[i]) begin
			if (noisy)
				first = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 99) == 0);
			else
				first = (i == 0);
			push_timing(durs[i], first, i == durs.size() - 1);
		end
	endtask

	initial begin
		logic [CFG_DW-1:0] tw;
		logic [TOL_W-1:0] tol;
		logic [GAP_W-1:0] gap;
		int quota;
		int nb;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero duration, over-range durations, clean frames
		push_timing(16'd0, 1'b1, 1'b1);
		push_timing(16'hFFFF, 1'b1, 1'b0);
		push_timing(16'hFFFF, 1'b0, 1'b1);
		payload[0] = 8'h00;
		payload[1] = 8'hFF;
		payload[2] = 8'hA5;
		send_capture(3, 0, 1'b0);
		payload[0] = 8'h3C;
		send_capture(1, 2, 1'b0);
		payload[0] = 8'h81;
		send_capture(1, 1, 1'b0);
		// low stop slot: data all ones, then a low-level cell lands on the stop
		push_timing(16'd417, 1'b1, 1'b0);
		push_timing(16'd3336, 1'b0, 1'b0);
		push_timing(16'd417, 1'b0, 1'b1);
		// byte store runs full
		for (int i = 0; i < 17; i++)
			payload[i] = 8'h00;
		send_capture(17, 0, 1'b0);
		wait_idle();

		// zero tick behaves as a tick of one
		set_regs('0, '0, '0);
		payload[0] = 8'h5A;
		send_capture(1, 0, 1'b0);
		push_timing(16'd0, 1'b1, 1'b1);
		wait_idle();

		quota = RANDOM_ITEMS / PHASES;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_regs(CFG_DW'(TICK_RST), TOL_RST, GAP_RST);
				1: set_regs(CFG_DW'(1), '0, '0);
				2: set_regs(CFG_DW'(7000), 16'hFFFF, 16'hFFFF);
				default: begin
					tw = {3'($urandom_range(0, 7)), 13'($urandom_range(1, 7000))};
					case ($urandom_range(0, 3))
						0: tol = TOL_W'($urandom);
						1: tol = TOL_W'($urandom_range(0, 20));
						default: tol = TOL_W'($urandom_range(0, tw[TICK_W-1:0] / 2));
					endcase
					gap = GAP_W'($urandom);
					set_regs(tw, tol, gap);
				end
			endcase
			src_idle = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
			snk_idle = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
			if (ph == 3)
				hold_req = 1'b1;
			sent = 0;
			while (sent < quota) begin
				if ($urandom_range(0, 99) < 85) begin
					nb = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 20) :
						$urandom_range(1, 4);
					for (int i = 0; i < nb; i++)
						payload[i] = 8'($urandom);
					send_capture(nb, $urandom_range(0, 2), 1'b1);
				end else begin
					repeat ($urandom_range(1, 6))
						push_timing(DUR_W'($urandom), $urandom_range(0, 3) == 0,
							$urandom_range(0, 3) == 0);
				end
			end
			wait_idle();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("[ir_async_frame_decoder] OK");
		else
			$display("[ir_async_frame_decoder] ERROR");
		$finish;
	end

endmodule
